FILE: rtl/g4rle_pkg.sv
// Shared types, constants and run-coding helpers for the 4-bit gray RLE block.
// No dependencies; imported by every module under rtl/.
package g4rle_pkg;

   localparam int CSR_W              = 3;
   localparam int LEN_W              = 28;
   localparam int DEF_MAX_COMPONENTS = 4;
   localparam int DEF_QUEUE_DEPTH    = 4;

   localparam logic [CSR_W-1:0] COUNT_RESET = 3'd1;
   localparam logic [7:0]       START_BYTE  = 8'h55;
   localparam logic [LEN_W-1:0] BW_LIMIT    = 28'hFFF_FFFF;
   localparam logic [LEN_W-1:0] GRAY_LIMIT  = 28'h000_000F;
   localparam logic [3:0]       LEVEL_BLACK = 4'h0;
   localparam logic [3:0]       LEVEL_WHITE = 4'hF;
   localparam logic [3:0]       GRAY_HDR    = 4'h4;
   localparam logic [3:0]       BLACK_CLASS = 4'h0;
   localparam logic [3:0]       WHITE_CLASS = 4'hC;

   // One queue entry: everything a single input word asks the back end to send.
   typedef struct packed {
      logic             start;
      logic             run1_vld;
      logic [3:0]       run1_level;
      logic [LEN_W-1:0] run1_len;
      logic             run2_vld;
      logic [3:0]       run2_level;
      logic [LEN_W-1:0] run2_len;
      logic             last;
   } entry_type;

   function automatic logic is_bw(input logic [3:0] level);
      return (level == LEVEL_BLACK) || (level == LEVEL_WHITE);
   endfunction

   // Number of bytes for a run, minus one.
   function automatic logic [1:0] run_span(input logic [3:0] level,
                                           input logic [LEN_W-1:0] len);
      logic [1:0] n;
      if (!is_bw(level))                  n = 2'd1;
      else if (len <= 28'h000_000F)       n = 2'd0;
      else if (len <= 28'h000_0FFF)       n = 2'd1;
      else if (len <= 28'h00F_FFFF)       n = 2'd2;
      else                                n = 2'd3;
      return n;
   endfunction

   function automatic logic [7:0] run_byte(input logic [3:0] level,
                                           input logic [LEN_W-1:0] len,
                                           input logic [1:0] idx);
      logic [1:0] span;
      logic [1:0] pos;
      logic [3:0] nib;
      logic [3:0] cls;
      logic [7:0] b;
      span = run_span(level, len);
      pos  = span - idx;
      cls  = (level == LEVEL_BLACK) ? BLACK_CLASS : WHITE_CLASS;
      case (span)
         2'd0:    nib = len[3:0];
         2'd1:    nib = len[11:8];
         2'd2:    nib = len[19:16];
         default: nib = len[27:24];
      endcase
      if (!is_bw(level)) begin
         b = (idx == 2'd0) ? {GRAY_HDR, len[3:0]} : {4'h0, level};
      end else if (idx == 2'd0) begin
         b = {cls | {2'b00, span}, nib};
      end else begin
         case (pos)
            2'd0:    b = len[7:0];
            2'd1:    b = len[15:8];
            2'd2:    b = len[23:16];
            default: b = {4'h0, len[27:24]};
         endcase
      end
      return b;
   endfunction

endpackage

FILE: rtl/g4rle_front.sv
// Front end: takes raster words, tracks pixel phase and the open run, and
// queues one entry of work per word that yields output. Uses g4rle_pkg.
module g4rle_front #(
   parameter int MAX_COMPONENTS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_wr_en,
   input  logic [g4rle_pkg::CSR_W-1:0]   csr_wr_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,
   input  logic                          req_tlast,
   output logic                          push,
   output g4rle_pkg::entry_type          push_entry,
   input  logic                          push_ready
);
   import g4rle_pkg::*;

   localparam int PHASE_W = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

   logic [CSR_W-1:0]   count_ff, count_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [3:0]         level_ff, level_in;
   logic [LEN_W-1:0]   length_ff, length_in;
   logic               open_ff, open_in;
   logic               hdr_sent_ff, hdr_sent_in;

   logic [CSR_W-1:0]   cnt;
   logic               accept;
   logic               first;
   logic [3:0]         level;
   logic               below;
   logic               cont;
   entry_type          e;

   always_comb begin
      cnt = count_ff;
      if (count_ff == '0) cnt = CSR_W'(1);
      else if ({1'b0, count_ff} > 4'(MAX_COMPONENTS)) cnt = CSR_W'(MAX_COMPONENTS);

      accept = req_tvalid && push_ready;
      first  = (phase_ff == '0);
      level  = req_tdata[7:4];
      below  = is_bw(level) ? (length_ff < BW_LIMIT) : (length_ff < GRAY_LIMIT);
      cont   = open_ff && (level_ff == level) && below;

      count_in    = csr_wr_en ? csr_wr_data : count_ff;
      level_in    = level_ff;
      length_in   = length_ff;
      open_in     = open_ff;
      hdr_sent_in = hdr_sent_ff;

      e            = '0;
      e.start      = first && !hdr_sent_ff;
      e.run1_level = level_ff;
      e.run1_len   = length_ff;
      e.run1_vld   = first && open_ff && !cont;
      e.last       = req_tlast;

      if (first) begin
         hdr_sent_in = 1'b1;
         level_in    = level;
         length_in   = cont ? length_ff + LEN_W'(1) : LEN_W'(1);
         open_in     = 1'b1;
      end

      e.run2_vld   = req_tlast && open_in;
      e.run2_level = level_in;
      e.run2_len   = length_in;

      if ((4'(phase_ff) + 4'd1) >= {1'b0, cnt}) phase_in = '0;
      else phase_in = phase_ff + PHASE_W'(1);

      if (req_tlast) begin
         level_in    = '0;
         length_in   = '0;
         open_in     = 1'b0;
         hdr_sent_in = 1'b0;
         phase_in    = '0;
      end
   end

   assign req_tready = push_ready;
   assign push       = accept && (e.start || e.run1_vld || e.run2_vld || e.last);
   assign push_entry = e;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= COUNT_RESET;
         phase_ff    <= '0;
         level_ff    <= '0;
         length_ff   <= '0;
         open_ff     <= 1'b0;
         hdr_sent_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            phase_ff    <= phase_in;
            level_ff    <= level_in;
            length_ff   <= length_in;
            open_ff     <= open_in;
            hdr_sent_ff <= hdr_sent_in;
         end
      end
   end

endmodule

FILE: rtl/g4rle_fifo.sv
// Short flop-based queue of work entries between front and back end.
// Uses g4rle_pkg for the entry type.
module g4rle_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  g4rle_pkg::entry_type push_entry,
   output logic                 push_ready,
   input  logic                 pop,
   output g4rle_pkg::entry_type pop_entry,
   output logic                 pop_valid
);
   import g4rle_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   always_comb begin
      do_push   = push && push_ready;
      do_pop    = pop && pop_valid;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      if (do_push && !do_pop)      cnt_in = cnt_ff + CNT_W'(1);
      else if (do_pop && !do_push) cnt_in = cnt_ff - CNT_W'(1);
   end

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

FILE: rtl/g4rle_back.sv
// Back end: expands queued entries into code bytes, keeps the checksum and
// drives the output register. Uses g4rle_pkg.
module g4rle_back (
   input  logic                 clock,
   input  logic                 reset,
   input  g4rle_pkg::entry_type pop_entry,
   input  logic                 pop_valid,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);
   import g4rle_pkg::*;

   typedef enum logic [1:0] {SEC_START, SEC_RUN1, SEC_RUN2, SEC_SUM} sec_type;

   entry_type  work_ff, work_in;
   logic       busy_ff, busy_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] sum_ff, sum_in;
   logic       vld_ff, vld_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   sec_type    sec;
   logic [7:0] cur_byte;
   logic       sec_done;
   logic       emit;
   logic       more;

   always_comb begin
      if (work_ff.start)         sec = SEC_START;
      else if (work_ff.run1_vld) sec = SEC_RUN1;
      else if (work_ff.run2_vld) sec = SEC_RUN2;
      else                       sec = SEC_SUM;

      unique case (sec)
         SEC_START: begin
            cur_byte = START_BYTE;
            sec_done = 1'b1;
         end
         SEC_RUN1: begin
            cur_byte = run_byte(work_ff.run1_level, work_ff.run1_len, idx_ff);
            sec_done = (idx_ff == run_span(work_ff.run1_level, work_ff.run1_len));
         end
         SEC_RUN2: begin
            cur_byte = run_byte(work_ff.run2_level, work_ff.run2_len, idx_ff);
            sec_done = (idx_ff == run_span(work_ff.run2_level, work_ff.run2_len));
         end
         default: begin
            cur_byte = sum_ff;
            sec_done = 1'b1;
         end
      endcase

      emit    = busy_ff && (!vld_ff || rsp_tready);
      work_in = work_ff;
      idx_in  = idx_ff;
      sum_in  = sum_ff;
      vld_in  = vld_ff && !rsp_tready;
      data_in = data_ff;
      last_in = last_ff;

      if (emit) begin
         vld_in  = 1'b1;
         data_in = cur_byte;
         last_in = (sec == SEC_SUM);
         idx_in  = sec_done ? 2'd0 : idx_ff + 2'd1;
         if (sec_done) begin
            unique case (sec)
               SEC_START: work_in.start    = 1'b0;
               SEC_RUN1:  work_in.run1_vld = 1'b0;
               SEC_RUN2:  work_in.run2_vld = 1'b0;
               default:   work_in.last     = 1'b0;
            endcase
         end
         if (sec == SEC_RUN1 || sec == SEC_RUN2) sum_in = sum_ff + cur_byte;
         else if (sec == SEC_SUM)                sum_in = '0;
      end

      more    = work_in.start || work_in.run1_vld || work_in.run2_vld || work_in.last;
      busy_in = busy_ff && more;
      pop     = pop_valid && !busy_in;
      if (pop) begin
         work_in = pop_entry;
         busy_in = 1'b1;
         idx_in  = 2'd0;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         sum_ff  <= '0;
         vld_ff  <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         sum_ff  <= sum_in;
         vld_ff  <= vld_in;
      end
      work_ff <= work_in;
      data_ff <= data_in;
      last_ff <= last_in;
   end

endmodule

FILE: rtl/gray4_run_length_encoder.sv
// Top level of the 4-bit grayscale run-length encoder.
// Instantiates g4rle_front, g4rle_fifo and g4rle_back; uses g4rle_pkg.
//
// Usage: raster bytes enter on req_* in row order, req_tlast on the final byte
// of an image. Only the high nibble of each pixel's first component counts;
// csr_wr_data sets the bytes per pixel (0 acts as 1, values above
// MAX_COMPONENTS clamp). The user must see that it is written only while the
// block is idle; the block does not enforce this. Code bytes leave on rsp_*:
// start byte 0x55, run codes, and a checksum word flagged by rsp_tlast. After
// it, the next input byte opens a new image. An accepted word's entry is
// queued, then loaded into the back end's work register, before its first
// code word is registered. Input is taken one word per cycle while the work
// queue has room; the output register emits one code word per cycle while
// rsp_tready is high, so in the long run input waits on the code words produced.
// Reset clears the run state, empties the queue and drops the output valid;
// no clearing sweep. When rsp_tready is low the output word holds, the queue
// fills and req_tready drops once QUEUE_DEPTH entries are waiting.
module gray4_run_length_encoder #(
   parameter int MAX_COMPONENTS = g4rle_pkg::DEF_MAX_COMPONENTS,
   parameter int QUEUE_DEPTH    = g4rle_pkg::DEF_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [g4rle_pkg::CSR_W-1:0] csr_wr_data,  // component_count
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,    // [7:0] pixel_byte
   input  logic                        req_tlast,    // end_of_image
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,    // [7:0] code_byte
   output logic                        rsp_tlast     // last_byte
);
   import g4rle_pkg::*;

   entry_type push_entry, pop_entry;
   logic      push, push_ready, pop, pop_valid;

   g4rle_front #(.MAX_COMPONENTS(MAX_COMPONENTS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .push        (push),
      .push_entry  (push_entry),
      .push_ready  (push_ready)
   );

   g4rle_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid)
   );

   g4rle_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_entry  (pop_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: rtl/g4rle_checker.sv
// Port-level checker for gray4_run_length_encoder, bound to the top level.
// Uses g4rle_pkg for the start byte.
module g4rle_props (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import g4rle_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_start_after_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=>
         !rsp_tvalid || (rsp_tdata == START_BYTE && !rsp_tlast))
      else $error("word after checksum is not a start byte");

endmodule

bind gray4_run_length_encoder g4rle_props u_g4rle_props (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
